[sv/smpc_pkg.sv]
// shared types, constants and helpers of the substring match positions block
`default_nettype none

package smpc_pkg;

   // defaults for the top level parameters
   localparam int PAT_MAX_DEFAULT  = 8;
   localparam int POS_BITS_DEFAULT = 16;

   // fixed field widths
   localparam int TEXT_W     = 8;
   localparam int LEN_W      = 4;
   localparam int PAT_W      = 64;
   localparam int PAT_BYTES  = PAT_W / TEXT_W;
   localparam int PAT_SEL_W  = $clog2(PAT_BYTES);
   localparam int POS_OUT_W  = 16;
   localparam int CNT_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   localparam logic [POS_OUT_W-1:0] POS_OUT_MAX = '1;
   localparam logic [CNT_W-1:0]     CNT_MAX     = '1;

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_BYTES  = 2'd0,
      CSR_PATTERN_LENGTH = 2'd1,
      CSR_START_POSITION = 2'd2
   } csr_index_type;

   // one result word
   typedef struct packed {
      logic                 match_valid;
      logic [POS_OUT_W-1:0] match_position;
      logic                 end_of_text;
      logic [CNT_W-1:0]     match_total;
      logic                 overflow;
   } rsp_word_type;

   // per byte control handed from the cell row to the tally
   typedef struct packed {
      logic take;
      logic last;
      logic hit;
   } step_type;

   // pattern byte k, bytes past the register read as zero
   function automatic logic [TEXT_W-1:0] pat_byte(input logic [PAT_W-1:0] pattern,
                                                  input logic [LEN_W-1:0] k);
      logic [TEXT_W-1:0] r;
      r = '0;
      if (int'(k) < PAT_BYTES) begin
         r = pattern[TEXT_W * int'(k[PAT_SEL_W-1:0]) +: TEXT_W];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[sv/smpc_if.sv]
// channel interfaces: text input, result output and configuration writes
`default_nettype none

interface smpc_req_if import smpc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TEXT_W-1:0] text_byte;
   logic              last_byte;

   modport source (output valid, output text_byte, output last_byte, input ready);
   modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface smpc_rsp_if import smpc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 match_valid;
   logic [POS_OUT_W-1:0] match_position;
   logic                 end_of_text;
   logic [CNT_W-1:0]     match_total;
   logic                 overflow;

   modport source (output valid, output match_valid, output match_position,
                   output end_of_text, output match_total, output overflow, input ready);
   modport sink   (input valid, input match_valid, input match_position,
                   input end_of_text, input match_total, input overflow, output ready);
endinterface

interface smpc_csr_if import smpc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/substring_match_positions_core.sv]
// Streaming matcher that reports the start of every occurrence at or after the start
// position of a configured pattern of up to eight bytes (overlaps included) and closes
// each text with a match count. Text bytes are taken at one per clock while the output
// buffer has room: a row of PAT_MAX-1 cells holds the most recent bytes and compares all
// of them against the pattern in the cycle a byte arrives, so the next byte can follow at
// once. A skid register behind the output register lets input keep flowing while one
// result waits; req_chan.ready drops only when both are occupied. Configuration writes
// are taken every cycle and apply from the next byte; no start-up clearing is needed.
`default_nettype none

module substring_match_positions_core import smpc_pkg::*; #(
   parameter int PAT_MAX  = PAT_MAX_DEFAULT,
   parameter int POS_BITS = POS_BITS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   smpc_req_if.sink   req_chan,
   smpc_rsp_if.source rsp_chan,
   smpc_csr_if.sink   csr_chan
);

   logic [PAT_W-1:0]     pattern_bytes_ff;
   logic [LEN_W-1:0]     pattern_length_ff;
   logic [POS_OUT_W-1:0] start_position_ff;

   logic [LEN_W-1:0]     len;
   logic                 take;
   logic                 full;
   logic [PAT_MAX-1:0]   ok_vec;
   logic [TEXT_W-1:0]    chain_byte [PAT_MAX];
   logic                 chain_vld  [PAT_MAX];
   step_type             step;
   logic                 push;
   rsp_word_type         push_word;

   // configuration registers
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff  <= '0;
         pattern_length_ff <= '0;
         start_position_ff <= '0;
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_PATTERN_BYTES: begin
               pattern_bytes_ff <= csr_chan.data;
            end
            CSR_PATTERN_LENGTH: begin
               pattern_length_ff <= csr_chan.data[LEN_W-1:0];
            end
            CSR_START_POSITION: begin
               start_position_ff <= csr_chan.data[POS_OUT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // effective pattern length, capped at the window size
   assign len = (int'(pattern_length_ff) > PAT_MAX) ? LEN_W'(PAT_MAX) : pattern_length_ff;

   // input handshake
   assign req_chan.ready = !full;
   assign take           = req_chan.valid && !full;

   // current byte against the last pattern byte
   assign chain_byte[0] = req_chan.text_byte;
   assign chain_vld[0]  = 1'b1;
   assign ok_vec[0]     = pat_byte(pattern_bytes_ff, len - LEN_W'(1)) == req_chan.text_byte;

   // row of window cells, cell i holds the byte i+1 places back
   for (genvar i = 0; i < PAT_MAX - 1; i++) begin : g_cell
      smpc_cell #(
         .IDX (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .take     (take),
         .clear    (take && req_chan.last_byte),
         .in_byte  (chain_byte[i]),
         .in_vld   (chain_vld[i]),
         .pattern  (pattern_bytes_ff),
         .len      (len),
         .out_byte (chain_byte[i+1]),
         .out_vld  (chain_vld[i+1]),
         .ok       (ok_vec[i+1])
      );
   end

   // full window agreement
   always_comb begin
      step.take = take;
      step.last = req_chan.last_byte;
      step.hit  = (len != '0) && (&ok_vec);
   end

   smpc_tally #(
      .POS_BITS (POS_BITS)
   ) u_tally (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .len            (len),
      .start_position (start_position_ff),
      .push           (push),
      .word           (push_word)
   );

   smpc_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (full),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

[sv/smpc_cell.sv]
// one window cell: holds a past text byte, compares it, shifts it on
`default_nettype none

module smpc_cell import smpc_pkg::*; #(
   parameter int IDX = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              take,
   input  wire logic              clear,
   input  wire logic [TEXT_W-1:0] in_byte,
   input  wire logic              in_vld,
   input  wire logic [PAT_W-1:0]  pattern,
   input  wire logic [LEN_W-1:0]  len,
   output logic      [TEXT_W-1:0] out_byte,
   output logic                   out_vld,
   output logic                   ok
);

   logic [TEXT_W-1:0] char_ff;
   logic              vld_ff;
   logic              care;
   logic [LEN_W-1:0]  sel;

   // valid bit: byte belongs to the current text
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (clear) begin
         vld_ff <= 1'b0;
      end else if (take) begin
         vld_ff <= in_vld;
      end
   end

   // stored byte shifts on each accepted word
   always_ff @(posedge clock) begin
      if (take) begin
         char_ff <= in_byte;
      end
   end

   // this cell lines up with pattern byte len-2-IDX when the pattern reaches it
   always_comb begin
      care = int'(len) > IDX + 1;
      sel  = len - LEN_W'(IDX + 2);
      ok   = !care || (vld_ff && (char_ff == pat_byte(pattern, sel)));
   end

   assign out_byte = char_ff;
   assign out_vld  = vld_ff;

endmodule

`default_nettype wire

[sv/smpc_tally.sv]
// position, match count and overflow tracking; builds the result word
`default_nettype none

module smpc_tally import smpc_pkg::*; #(
   parameter int POS_BITS = POS_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire step_type             step,
   input  wire logic [LEN_W-1:0]     len,
   input  wire logic [POS_OUT_W-1:0] start_position,
   output logic                      push,
   output rsp_word_type              word
);

   localparam int CMP_W = (POS_BITS > POS_OUT_W) ? POS_BITS : POS_OUT_W;
   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic                pos_full_ff, pos_full_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                sat_ff, sat_in;

   logic [POS_BITS-1:0] lenm1;
   logic [POS_BITS-1:0] start_at;
   logic [CMP_W-1:0]    start_w;
   logic                below;
   logic                big;
   logic                hit;
   logic                sat_now;
   logic [CNT_W-1:0]    cnt_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         pos_full_ff <= 1'b0;
         count_ff    <= '0;
         sat_ff      <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         pos_full_ff <= pos_full_in;
         count_ff    <= count_in;
         sat_ff      <= sat_in;
      end
   end

   // start of the occurrence, start filter and clamping
   always_comb begin
      lenm1    = POS_BITS'(len) - POS_BITS'(1);
      start_at = pos_ff - lenm1;
      start_w  = CMP_W'(start_at);
      below    = start_w < CMP_W'(start_position);
      big      = start_w > CMP_W'(POS_OUT_MAX);
      hit      = step.hit && !below;
   end

   // count and overflow for this byte
   always_comb begin
      sat_now = sat_ff | pos_full_ff;
      cnt_new = count_ff;
      if (hit) begin
         if (big) begin
            sat_now = 1'b1;
         end
         if (count_ff != CNT_MAX) begin
            cnt_new = count_ff + CNT_W'(1);
         end else begin
            sat_now = 1'b1;
         end
      end
   end

   // result word
   always_comb begin
      push                = step.take && (hit || step.last);
      word.match_valid    = hit;
      word.match_position = hit ? (big ? POS_OUT_MAX : start_w[POS_OUT_W-1:0]) : '0;
      word.end_of_text    = step.last;
      word.match_total    = cnt_new;
      word.overflow       = sat_now;
   end

   // next state, cleared after the last byte of a text
   always_comb begin
      pos_in      = pos_ff;
      pos_full_in = pos_full_ff;
      count_in    = count_ff;
      sat_in      = sat_ff;
      if (step.take) begin
         if (step.last) begin
            pos_in      = '0;
            pos_full_in = 1'b0;
            count_in    = '0;
            sat_in      = 1'b0;
         end else begin
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + POS_BITS'(1);
            end else begin
               pos_full_in = 1'b1;
            end
            count_in = cnt_new;
            sat_in   = sat_now;
         end
      end
   end

endmodule

`default_nettype wire

[sv/smpc_outbuf.sv]
// two-entry output buffer: result register plus skid register
`default_nettype none

module smpc_outbuf import smpc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire rsp_word_type push_word,
   output logic              full,
   smpc_rsp_if.source        rsp_chan
);

   rsp_word_type main_ff, main_in;
   rsp_word_type skid_ff, skid_in;
   logic         main_vld_ff, main_vld_in;
   logic         skid_vld_ff, skid_vld_in;
   logic         pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         main_vld_ff <= main_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   // drain first, then place the new word in the first free slot
   always_comb begin
      pop         = main_vld_ff && rsp_chan.ready;
      main_in     = main_ff;
      skid_in     = skid_ff;
      main_vld_in = main_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (pop) begin
         if (skid_vld_ff) begin
            main_in     = skid_ff;
            skid_vld_in = 1'b0;
         end else begin
            main_vld_in = 1'b0;
         end
      end
      if (push) begin
         if (!main_vld_in) begin
            main_in     = push_word;
            main_vld_in = 1'b1;
         end else begin
            skid_in     = push_word;
            skid_vld_in = 1'b1;
         end
      end
   end

   assign full                    = skid_vld_ff;
   assign rsp_chan.valid          = main_vld_ff;
   assign rsp_chan.match_valid    = main_ff.match_valid;
   assign rsp_chan.match_position = main_ff.match_position;
   assign rsp_chan.end_of_text    = main_ff.end_of_text;
   assign rsp_chan.match_total    = main_ff.match_total;
   assign rsp_chan.overflow       = main_ff.overflow;

endmodule

`default_nettype wire

[test/substring_match_checker.sv]
// checker: follows the matcher from the observed words and compares every result word
module substring_match_checker import smpc_pkg::*; (
   input  logic clock,
   input  logic reset,
   smpc_req_if  req_mon,
   smpc_rsp_if  rsp_mon,
   smpc_csr_if  csr_mon,
   output int   error_count,
   output int   reports_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          WINDOW  = PAT_MAX_DEFAULT - 1;
   localparam int unsigned POS_TOP = (1 << POS_BITS_DEFAULT) - 1;

   // register copies
   logic [PAT_W-1:0]     pattern_reg;
   logic [LEN_W-1:0]     length_reg;
   logic [POS_OUT_W-1:0] start_reg;

   // per-text search state
   logic [TEXT_W-1:0] history [WINDOW];
   int unsigned       text_pos;
   logic              text_pos_full;
   int unsigned       history_fill;
   int unsigned       found;
   logic              text_overflow;

   // result words still to come, oldest first
   rsp_word_type report_queue[$];

   function automatic void clear_text();
      foreach (history[i]) history[i] = '0;
      text_pos      = 0;
      text_pos_full = 1'b0;
      history_fill  = 0;
      found         = 0;
      text_overflow = 1'b0;
   endfunction

   // one text byte through the matcher; returns 1 when it yields a result word
   function automatic logic search_step(input logic [TEXT_W-1:0] cur, input logic last,
                                        output rsp_word_type word);
      int unsigned width;
      int unsigned first_at;
      int          j;
      logic        hit;
      width = (length_reg > PAT_MAX_DEFAULT) ? PAT_MAX_DEFAULT : length_reg;
      hit   = 1'b0;
      word  = '0;
      if (text_pos_full) text_overflow = 1'b1;

      // window ending at this byte against the pattern
      if (width > 0 && history_fill + 1 >= width) begin
         hit = (pattern_reg[TEXT_W*(width-1) +: TEXT_W] == cur);
         for (j = 1; j < width; j++) begin
            if (pattern_reg[TEXT_W*(width-1-j) +: TEXT_W] != history[j-1]) hit = 1'b0;
         end
         if (hit) begin
            first_at = text_pos - (width - 1);
            if (first_at < start_reg) begin
               hit = 1'b0;
            end else begin
               if (first_at > POS_OUT_MAX) begin
                  first_at      = POS_OUT_MAX;
                  text_overflow = 1'b1;
               end
               word.match_position = POS_OUT_W'(first_at);
               if (found < CNT_MAX) found++;
               else text_overflow = 1'b1;
            end
         end
      end

      // slide the window and advance the position
      for (j = WINDOW - 1; j > 0; j--) history[j] = history[j-1];
      history[0] = cur;
      if (history_fill < WINDOW) history_fill++;
      if (text_pos < POS_TOP) text_pos++;
      else text_pos_full = 1'b1;

      word.match_valid = hit;
      word.end_of_text = last;
      word.match_total = CNT_W'(found);
      word.overflow    = text_overflow;
      if (last) clear_text();
      return hit || last;
   endfunction

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : observe
      rsp_word_type due;
      rsp_word_type fresh;
      if (reset) begin
         pattern_reg = '0;
         length_reg  = '0;
         start_reg   = '0;
         error_count = 0;
         clear_text();
         report_queue.delete();
      end else begin
         // result word against the oldest report due
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (report_queue.size() == 0) begin
               $error("result word with no report due");
               error_count++;
            end else begin
               due = report_queue.pop_front();
               compare_field("match_valid", due.match_valid, rsp_mon.match_valid);
               compare_field("match_position", due.match_position, rsp_mon.match_position);
               compare_field("end_of_text", due.end_of_text, rsp_mon.end_of_text);
               compare_field("match_total", due.match_total, rsp_mon.match_total);
               compare_field("overflow", due.overflow, rsp_mon.overflow);
            end
         end

         // text word uses the registers as they stood before this edge
         if (req_mon.valid && req_mon.ready) begin
            if (search_step(req_mon.text_byte, req_mon.last_byte, fresh))
               report_queue.push_back(fresh);
         end

         // register writes
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_index_type'(csr_mon.index))
               CSR_PATTERN_BYTES:  pattern_reg = csr_mon.data;
               CSR_PATTERN_LENGTH: length_reg  = csr_mon.data[LEN_W-1:0];
               CSR_START_POSITION: start_reg   = csr_mon.data[POS_OUT_W-1:0];
               default: ;
            endcase
         end
      end
      reports_due = report_queue.size();
   end

endmodule

[test/testbench.sv]
// testbench top: clock, reset, text and register stimulus, result stalls and the verdict
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import smpc_pkg::*;

   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int LONG_HOLD       = 400;
   localparam int PHASES          = 10;
   localparam int PHASE_ITEMS     = 110;

   typedef enum int {STALL_NONE, STALL_HALF, STALL_MOST} stall_mode_type;

   logic clock;
   logic reset;
   int   error_count;
   int   reports_due;
   int   idle_cycles;
   int   burst_left;
   logic hold_request;
   logic [TEXT_W-1:0] text_chars[$];

   smpc_req_if req_chan ();
   smpc_rsp_if rsp_chan ();
   smpc_csr_if csr_chan ();

   substring_match_positions_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   substring_match_checker match_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_mon     (csr_chan),
      .error_count (error_count),
      .reports_due (reports_due)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog on cycles with no word moving on any channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // result side stalls, with one long hold-off on request
   initial begin : result_stalls
      stall_mode_type mode;
      int             mode_left;
      int             hold_left;
      logic           hold_done;
      rsp_chan.ready = 1'b0;
      mode      = STALL_NONE;
      mode_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = stall_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(8, 60);
            end
            mode_left--;
            case (mode)
               STALL_NONE: rsp_chan.ready = 1'b1;
               STALL_HALF: rsp_chan.ready = 1'($urandom_range(0, 1));
               default:    rsp_chan.ready = ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // one text word, sent in bursts with random gaps between them
   task automatic send_byte(input logic [TEXT_W-1:0] value, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_chan.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 50);
      end
      burst_left--;
      req_chan.valid     = 1'b1;
      req_chan.text_byte = value;
      req_chan.last_byte = last;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic send_text();
      foreach (text_chars[i]) send_byte(text_chars[i], i == text_chars.size() - 1);
      text_chars.delete();
   endtask

   // drain every result and let the pipe settle
   task automatic wait_idle();
      req_chan.valid = 1'b0;
      while (reports_due != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // all three registers back to back while the block is idle
   task automatic set_config(input logic [PAT_W-1:0] pattern, input logic [LEN_W-1:0] length,
                             input logic [POS_OUT_W-1:0] first_pos);
      csr_index_type         idx  [3];
      logic [CSR_DATA_W-1:0] vals [3];
      int                    n;
      wait_idle();
      idx  = '{CSR_PATTERN_BYTES, CSR_PATTERN_LENGTH, CSR_START_POSITION};
      vals = '{pattern, CSR_DATA_W'(length), CSR_DATA_W'(first_pos)};
      for (n = 0; n < 3; n++) begin
         csr_chan.valid = 1'b1;
         csr_chan.index = idx[n];
         csr_chan.data  = vals[n];
         do @(posedge clock); while (!csr_chan.ready);
         @(negedge clock);
      end
      csr_chan.valid = 1'b0;
   endtask

   initial begin : stimulus
      logic [PAT_W-1:0]     pattern;
      logic [LEN_W-1:0]     length;
      logic [POS_OUT_W-1:0] start;
      logic [TEXT_W-1:0]    sym [2];
      int unsigned          width;
      int                   phase;
      int                   phase_items;
      int                   text_len;
      int                   pick;
      int                   k;

      reset              = 1'b1;
      hold_request       = 1'b0;
      burst_left         = 0;
      req_chan.valid     = 1'b0;
      req_chan.text_byte = '0;
      req_chan.last_byte = 1'b0;
      csr_chan.valid     = 1'b0;
      csr_chan.index     = CSR_PATTERN_BYTES;
      csr_chan.data      = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // matching off after reset: only the end of text reports
      text_chars = '{8'h00, 8'hFF, 8'h5A};
      send_text();

      // "a#": a full match followed by '#' still counts
      set_config(64'h2361, 4'd2, 16'd0);
      text_chars = '{8'h61, 8'h23, 8'h61, 8'h23, 8'h23};
      send_text();

      // length above the maximum acts as eight, early start ignored
      set_config('1, 4'd15, 16'd1);
      for (k = 0; k < 10; k++) text_chars.push_back(8'hFF);
      send_text();

      // start position at its top blocks everything
      set_config('0, 4'd1, 16'hFFFF);
      text_chars = '{8'h00, 8'h00, 8'h00};
      send_text();

      // random phases, each with its own setting
      for (phase = 0; phase < PHASES; phase++) begin
         sym[0] = TEXT_W'($urandom);
         sym[1] = sym[0] ^ (TEXT_W'(1) << $urandom_range(0, TEXT_W - 1));
         for (k = 0; k < PAT_BYTES; k++)
            pattern[TEXT_W*k +: TEXT_W] = ($urandom_range(0, 4) == 0) ?
                                          TEXT_W'($urandom) : sym[$urandom_range(0, 1)];
         length = LEN_W'($urandom_range(1, PAT_MAX_DEFAULT));
         start  = '0;
         case (phase)
            0: begin
               pattern = '1;
               length  = LEN_W'(PAT_MAX_DEFAULT);
               sym     = '{8'hFF, 8'h7F};
            end
            1: begin
               pattern = '0;
               length  = LEN_W'(PAT_MAX_DEFAULT);
               sym     = '{8'h00, 8'h80};
            end
            2: length = '0;
            3: length = '1;
            4: start = '1;
            5: start = POS_OUT_W'($urandom);
            6: length = LEN_W'(1);
            7: length = LEN_W'($urandom_range(PAT_MAX_DEFAULT + 1, 14));
            default: start = POS_OUT_W'($urandom_range(0, 8));
         endcase
         set_config(pattern, length, start);
         // long result hold-off while text keeps coming
         if (phase == 6) hold_request = 1'b1;

         width       = (length > PAT_MAX_DEFAULT) ? PAT_MAX_DEFAULT : length;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            text_len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 120)
                                                   : $urandom_range(1, 40);
            while (text_chars.size() < text_len) begin
               pick = $urandom_range(0, 9);
               if (pick < 3 && width > 0) begin
                  for (k = 0; k < width; k++)
                     text_chars.push_back(pattern[TEXT_W*k +: TEXT_W]);
               end else if (pick < 8) begin
                  text_chars.push_back(sym[$urandom_range(0, 1)]);
               end else begin
                  text_chars.push_back(TEXT_W'($urandom));
               end
            end
            phase_items += text_chars.size();
            send_text();
         end
      end

      wait_idle();
      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

[files.f]
sv/smpc_pkg.sv
sv/smpc_if.sv
sv/smpc_cell.sv
sv/smpc_tally.sv
sv/smpc_outbuf.sv
sv/substring_match_positions_core.sv
test/substring_match_checker.sv
test/testbench.sv
